// ----- hw/rtl/assert_macros.svh -----
// Assertion macros of the unpad gather address generator RTL, used by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a clock, switched off while the active-low reset is asserted.
`define UGA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent check on a clock that also holds while reset is asserted.
`define UGA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/uga_pkg.sv -----
// Shared widths, stage map, codes and types of the unpad gather address generator.
`default_nettype none

package uga_pkg;

    // Field widths.
    localparam int ADDR_BITS      = 31;
    localparam int DIM_BITS       = 12;
    localparam int BATCH_BITS     = 10;
    localparam int ELEM_BITS      = 24;
    localparam int MODE_BITS      = 2;
    localparam int CFG_INDEX_BITS = 2;

    // Derived arithmetic widths.
    localparam int PLANE_BITS  = 2 * DIM_BITS;
    localparam int STRIDE_BITS = 3 * DIM_BITS;
    localparam int COUNT_BITS  = 3 * DIM_BITS;
    localparam int DIV_BITS    = (ELEM_BITS > PLANE_BITS) ? ELEM_BITS : PLANE_BITS;
    localparam int CMP_BITS    = (ELEM_BITS > COUNT_BITS) ? ELEM_BITS : COUNT_BITS;
    localparam int T0_BITS     = BATCH_BITS + STRIDE_BITS;
    localparam int T1_BITS     = DIV_BITS + PLANE_BITS;
    localparam int T2_BITS     = DIV_BITS + DIM_BITS;
    localparam int SAT_BITS    = ADDR_BITS + 1;
    localparam int SUM2_BITS   = ADDR_BITS + 2;
    localparam int SUM4_BITS   = ADDR_BITS + 3;
    localparam int DST_BITS    = ((ADDR_BITS > ELEM_BITS) ? ADDR_BITS : ELEM_BITS) + 1;
    localparam int PROD_A      = (T0_BITS > T1_BITS) ? T0_BITS : T1_BITS;
    localparam int PROD_B      = (T2_BITS > SAT_BITS) ? T2_BITS : SAT_BITS;
    localparam int PROD_C      = (PROD_A > PROD_B) ? PROD_A : PROD_B;
    localparam int PROD_BITS   = (PROD_C > DIV_BITS) ? PROD_C : DIV_BITS;

    // Stage map of the main pipeline (register stage indices).
    localparam int DIV_STAGES    = DIV_BITS;
    localparam int ST_IN         = 0;
    localparam int ST_PREP       = 1;
    localparam int ST_CNT        = 2;
    localparam int ST_CHK        = 3;
    localparam int ST_DIVA_LAST  = ST_PREP + DIV_STAGES;
    localparam int ST_DIVB_FIRST = ST_DIVA_LAST + 1;
    localparam int ST_DIVB_LAST  = ST_DIVA_LAST + DIV_STAGES;
    localparam int ST_MUL        = ST_DIVB_LAST + 1;
    localparam int ST_SUM        = ST_MUL + 1;
    localparam int PIPE_STAGES   = ST_SUM + 1;

    // Operating modes.
    typedef enum logic [MODE_BITS-1:0] {
        MODE_2D    = 2'd0,
        MODE_3D    = 2'd1,
        MODE_T0213 = 2'd2
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MODE             = 2'd0,
        CFG_PADDED_DIM_ONE   = 2'd1,
        CFG_PADDED_DIM_TWO   = 2'd2,
        CFG_PADDED_DIM_THREE = 2'd3
    } cfg_index_t;

    localparam logic [MODE_BITS-1:0] MODE_RESET = MODE_3D;
    localparam logic [DIM_BITS-1:0]  DIM_RESET  = DIM_BITS'(1);

    // Per-item data that rides along the divider stages.
    typedef struct packed {
        logic [BATCH_BITS-1:0] n;
        logic [ADDR_BITS-1:0]  dst;
        logic [DIM_BITS-1:0]   c;
        logic                  ok;
    } side_t;

    // First quotient and remainder, carried beside the second divider.
    typedef struct packed {
        logic [DIV_BITS-1:0] q;
        logic [DIV_BITS-1:0] r;
    } quo_rem_t;

    // One result beat.
    typedef struct packed {
        logic [ADDR_BITS-1:0] src;
        logic [ADDR_BITS-1:0] dst;
        logic                 in_range;
    } out_t;

    // Clamp a term at 2^ADDR_BITS; sums of clamped terms overflow exactly when
    // the exact sums do.
    function automatic logic [SAT_BITS-1:0] sat_term(input logic [PROD_BITS-1:0] v);
        logic [SAT_BITS-1:0] res;
        if (v >= (PROD_BITS'(1) << ADDR_BITS)) begin
            res = SAT_BITS'(1) << ADDR_BITS;
        end else begin
            res = v[SAT_BITS-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/unpad_gather_address_gen_top.sv -----
// Top level of the unpad gather address generator: a fixed-depth address pipeline.
// Usage:
//   Each input beat on s_* describes one packed element: batch index, element
//   index, the batch's true sizes and its packed base offset. Each beat yields
//   exactly one result beat on m_* with the padded source index, the packed
//   destination index and in_range; both indices read 0 when in_range is low.
//   The cfg_we/cfg_index/cfg_data port writes mode and the padded sizes; the user
//   must use it only while no beat is in flight, which the block does not enforce.
//   Throughput is one beat per cycle while the output buffer has a free entry.
//   The depth comes from two 24-stage bit-per-stage dividers in series (element
//   by columns or plane, then the remainder by the inner size or head size),
//   plus prep, multiply and sum.
//   A two-entry output buffer holds finished results; the whole pipeline
//   advances while that buffer has a free entry, so s_ready drops only when
//   two results wait in it.
//   Reset (aresetn low, synchronous) empties the pipeline and the buffer and
//   restores mode to three-dim output and all padded sizes to one.
`default_nettype none
`include "assert_macros.svh"

module unpad_gather_address_gen_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [uga_pkg::BATCH_BITS-1:0] s_batch_index,
    input  logic [uga_pkg::ELEM_BITS-1:0]  s_elem_index,
    input  logic [uga_pkg::DIM_BITS-1:0]   s_true_size_a,
    input  logic [uga_pkg::DIM_BITS-1:0]   s_true_size_b,
    input  logic [uga_pkg::DIM_BITS-1:0]   s_true_size_c,
    input  logic [uga_pkg::ADDR_BITS-1:0]  s_batch_base,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [uga_pkg::ADDR_BITS-1:0]  m_src_index,
    output logic [uga_pkg::ADDR_BITS-1:0]  m_dst_index,
    output logic                           m_in_range,
    input  logic                           cfg_we,
    input  logic [uga_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [uga_pkg::DIM_BITS-1:0]   cfg_data
);

    localparam int LAST = uga_pkg::PIPE_STAGES - 1;
    localparam logic [1:0] BUF_EMPTY = 2'd0;
    localparam logic [1:0] BUF_ONE   = 2'd1;
    localparam logic [1:0] BUF_FULL  = 2'd2;

    // Configuration registers.
    logic [uga_pkg::MODE_BITS-1:0] mode_reg;
    logic [uga_pkg::DIM_BITS-1:0]  p1_reg;
    logic [uga_pkg::DIM_BITS-1:0]  p2_reg;
    logic [uga_pkg::DIM_BITS-1:0]  p3_reg;
    uga_pkg::mode_t                mode;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= uga_pkg::MODE_RESET;
            p1_reg   <= uga_pkg::DIM_RESET;
            p2_reg   <= uga_pkg::DIM_RESET;
            p3_reg   <= uga_pkg::DIM_RESET;
        end else if (cfg_we) begin
            unique case (uga_pkg::cfg_index_t'(cfg_index))
                uga_pkg::CFG_MODE:             mode_reg <= cfg_data[uga_pkg::MODE_BITS-1:0];
                uga_pkg::CFG_PADDED_DIM_ONE:   p1_reg   <= cfg_data;
                uga_pkg::CFG_PADDED_DIM_TWO:   p2_reg   <= cfg_data;
                uga_pkg::CFG_PADDED_DIM_THREE: p3_reg   <= cfg_data;
            endcase
        end
    end

    assign mode = uga_pkg::mode_t'(mode_reg);

    // Strides derived from the padded sizes, registered in p12_reg, stride_reg and
    // plane_reg; they settle long before any item reaches the multiply stage.
    logic [uga_pkg::PLANE_BITS-1:0]  p12_reg;
    logic [uga_pkg::PLANE_BITS-1:0]  plane_reg;
    logic [uga_pkg::STRIDE_BITS-1:0] stride_reg;
    logic [uga_pkg::STRIDE_BITS-1:0] stride_next;

    always_comb begin
        if (mode == uga_pkg::MODE_2D) begin
            stride_next = uga_pkg::STRIDE_BITS'(p12_reg);
        end else begin
            stride_next = uga_pkg::STRIDE_BITS'(p12_reg) * uga_pkg::STRIDE_BITS'(p3_reg);
        end
    end

    always_ff @(posedge aclk) begin
        p12_reg    <= uga_pkg::PLANE_BITS'(p1_reg) * uga_pkg::PLANE_BITS'(p2_reg);
        plane_reg  <= uga_pkg::PLANE_BITS'(p2_reg) * uga_pkg::PLANE_BITS'(p3_reg);
        stride_reg <= stride_next;
    end

    // Global advance: the pipeline moves whenever the output buffer has room.
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       adv;
    logic       v_reg [0:LAST];

    assign adv     = (count_reg != BUF_FULL);
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= LAST; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            v_reg[0] <= s_valid;
            for (int k = 1; k <= LAST; k++) begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // Input capture stage.
    logic [uga_pkg::BATCH_BITS-1:0] n0_reg;
    logic [uga_pkg::ELEM_BITS-1:0]  e0_reg;
    logic [uga_pkg::DIM_BITS-1:0]   a0_reg;
    logic [uga_pkg::DIM_BITS-1:0]   b0_reg;
    logic [uga_pkg::DIM_BITS-1:0]   c0_reg;
    logic [uga_pkg::ADDR_BITS-1:0]  base0_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            n0_reg    <= s_batch_index;
            e0_reg    <= s_elem_index;
            a0_reg    <= s_true_size_a;
            b0_reg    <= s_true_size_b;
            c0_reg    <= s_true_size_c;
            base0_reg <= s_batch_base;
        end
    end

    // Prep stage: size products, first divisor, divisor checks and destination.
    logic [uga_pkg::PLANE_BITS-1:0] ab_next;
    logic [uga_pkg::PLANE_BITS-1:0] bc_next;
    logic [uga_pkg::DIV_BITS-1:0]   d1_next;
    logic [uga_pkg::DST_BITS-1:0]   dst_sum;
    logic                           bad_div;
    logic                           dst_ovf;
    uga_pkg::side_t                 side_prep;
    uga_pkg::side_t                 side_next [uga_pkg::ST_PREP:uga_pkg::ST_DIVB_LAST];
    uga_pkg::side_t                 side_reg  [uga_pkg::ST_PREP:uga_pkg::ST_DIVB_LAST];

    always_comb begin
        ab_next = uga_pkg::PLANE_BITS'(a0_reg) * uga_pkg::PLANE_BITS'(b0_reg);
        bc_next = uga_pkg::PLANE_BITS'(b0_reg) * uga_pkg::PLANE_BITS'(c0_reg);
        unique case (mode)
            uga_pkg::MODE_2D: begin
                bad_div = (b0_reg == '0);
                d1_next = uga_pkg::DIV_BITS'(b0_reg);
            end
            uga_pkg::MODE_3D: begin
                bad_div = (bc_next == '0);
                d1_next = uga_pkg::DIV_BITS'(bc_next);
            end
            uga_pkg::MODE_T0213: begin
                bad_div = (b0_reg == '0) || (p1_reg == '0);
                d1_next = uga_pkg::DIV_BITS'(b0_reg);
            end
            default: begin
                // The unused mode code never yields a valid result.
                bad_div = 1'b1;
                d1_next = uga_pkg::DIV_BITS'(b0_reg);
            end
        endcase
        dst_sum = uga_pkg::DST_BITS'(base0_reg) + uga_pkg::DST_BITS'(e0_reg);
        dst_ovf = (dst_sum >= (uga_pkg::DST_BITS'(1) << uga_pkg::ADDR_BITS));
        side_prep.n   = n0_reg;
        side_prep.dst = dst_sum[uga_pkg::ADDR_BITS-1:0];
        side_prep.c   = c0_reg;
        side_prep.ok  = !bad_div && !dst_ovf;
    end

    logic [uga_pkg::ELEM_BITS-1:0]  e1_reg;
    logic [uga_pkg::DIV_BITS-1:0]   d1_reg;
    logic [uga_pkg::PLANE_BITS-1:0] ab1_reg;
    logic [uga_pkg::DIM_BITS-1:0]   b1_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            e1_reg  <= e0_reg;
            d1_reg  <= d1_next;
            ab1_reg <= ab_next;
            b1_reg  <= b0_reg;
        end
    end

    // Element count of the batch, then the bound check in the stage after it.
    logic [uga_pkg::COUNT_BITS-1:0] cnt2_reg;
    logic [uga_pkg::COUNT_BITS-1:0] cnt2_next;
    logic [uga_pkg::ELEM_BITS-1:0]  e2_reg;
    logic                           cnt_ok;

    always_comb begin
        if (mode == uga_pkg::MODE_3D) begin
            cnt2_next = uga_pkg::COUNT_BITS'(ab1_reg)
                      * uga_pkg::COUNT_BITS'(side_reg[uga_pkg::ST_PREP].c);
        end else begin
            cnt2_next = uga_pkg::COUNT_BITS'(ab1_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cnt2_reg <= cnt2_next;
            e2_reg   <= e1_reg;
        end
    end

    assign cnt_ok = (uga_pkg::CMP_BITS'(e2_reg) < uga_pkg::CMP_BITS'(cnt2_reg));

    // First divider: element index by columns (or by the plane in three-dim mode).
    // The head size divider runs beside it.
    logic [uga_pkg::DIV_BITS-1:0] qa;
    logic [uga_pkg::DIV_BITS-1:0] ra;
    logic [uga_pkg::DIV_BITS-1:0] head;

    uga_div_pipe u_div_elem (
        .aclk      (aclk),
        .en        (adv),
        .dividend  (uga_pkg::DIV_BITS'(e1_reg)),
        .divisor   (d1_reg),
        .quotient  (qa),
        .remainder (ra)
    );

    uga_div_pipe u_div_head (
        .aclk      (aclk),
        .en        (adv),
        .dividend  (uga_pkg::DIV_BITS'(b1_reg)),
        .divisor   (uga_pkg::DIV_BITS'(p1_reg)),
        .quotient  (head),
        .remainder ()
    );

    // Second divider: the first remainder by the inner size or the head size.
    logic [uga_pkg::DIV_BITS-1:0] d2;
    logic [uga_pkg::DIV_BITS-1:0] qb;
    logic [uga_pkg::DIV_BITS-1:0] rb;

    assign d2 = (mode == uga_pkg::MODE_3D)
              ? uga_pkg::DIV_BITS'(side_reg[uga_pkg::ST_DIVA_LAST].c) : head;

    uga_div_pipe u_div_inner (
        .aclk      (aclk),
        .en        (adv),
        .dividend  (ra),
        .divisor   (d2),
        .quotient  (qb),
        .remainder (rb)
    );

    // Side data follows the dividers; the bound check and the head size check
    // fold into the valid flag at their stages.
    uga_pkg::quo_rem_t qr_reg [0:uga_pkg::DIV_STAGES-1];

    always_comb begin
        side_next[uga_pkg::ST_PREP] = side_prep;
        for (int k = uga_pkg::ST_PREP + 1; k <= uga_pkg::ST_DIVB_LAST; k++) begin
            side_next[k] = side_reg[k-1];
            if (k == uga_pkg::ST_CHK) begin
                side_next[k].ok = side_reg[k-1].ok && cnt_ok;
            end
            if (k == uga_pkg::ST_DIVB_FIRST) begin
                side_next[k].ok = side_reg[k-1].ok
                               && !((mode == uga_pkg::MODE_T0213) && (head == '0));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = uga_pkg::ST_PREP; k <= uga_pkg::ST_DIVB_LAST; k++) begin
                side_reg[k] <= side_next[k];
            end
            qr_reg[0].q <= qa;
            qr_reg[0].r <= ra;
            for (int k = 1; k < uga_pkg::DIV_STAGES; k++) begin
                qr_reg[k] <= qr_reg[k-1];
            end
        end
    end

    // Multiply stage: the four terms of the source index.
    uga_pkg::side_t                 side_b;
    uga_pkg::quo_rem_t              qr_b;
    logic [uga_pkg::DIV_BITS-1:0]   x1;
    logic [uga_pkg::PLANE_BITS-1:0] y1;
    logic [uga_pkg::DIV_BITS-1:0]   x2;
    logic [uga_pkg::DIV_BITS-1:0]   x3;
    logic [uga_pkg::T0_BITS-1:0]    t0_reg;
    logic [uga_pkg::T1_BITS-1:0]    t1_reg;
    logic [uga_pkg::T2_BITS-1:0]    t2_reg;
    logic [uga_pkg::DIV_BITS-1:0]   t3_reg;
    logic [uga_pkg::ADDR_BITS-1:0]  mul_dst_reg;
    logic                           mul_ok_reg;

    assign side_b = side_reg[uga_pkg::ST_DIVB_LAST];
    assign qr_b   = qr_reg[uga_pkg::DIV_STAGES-1];

    always_comb begin
        unique case (mode)
            uga_pkg::MODE_2D: begin
                x1 = qr_b.q;
                y1 = uga_pkg::PLANE_BITS'(p2_reg);
                x2 = '0;
                x3 = qr_b.r;
            end
            uga_pkg::MODE_3D: begin
                x1 = qr_b.q;
                y1 = plane_reg;
                x2 = qb;
                x3 = rb;
            end
            uga_pkg::MODE_T0213: begin
                x1 = qb;
                y1 = plane_reg;
                x2 = qr_b.q;
                x3 = rb;
            end
            default: begin
                x1 = '0;
                y1 = '0;
                x2 = '0;
                x3 = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t0_reg      <= uga_pkg::T0_BITS'(side_b.n) * uga_pkg::T0_BITS'(stride_reg);
            t1_reg      <= uga_pkg::T1_BITS'(x1) * uga_pkg::T1_BITS'(y1);
            t2_reg      <= uga_pkg::T2_BITS'(x2) * uga_pkg::T2_BITS'(p3_reg);
            t3_reg      <= x3;
            mul_dst_reg <= side_b.dst;
            mul_ok_reg  <= side_b.ok;
        end
    end

    // Partial sums of the clamped terms.
    logic [uga_pkg::SUM2_BITS-1:0] s01_reg;
    logic [uga_pkg::SUM2_BITS-1:0] s23_reg;
    logic [uga_pkg::ADDR_BITS-1:0] sum_dst_reg;
    logic                          sum_ok_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s01_reg <= uga_pkg::SUM2_BITS'(uga_pkg::sat_term(uga_pkg::PROD_BITS'(t0_reg)))
                     + uga_pkg::SUM2_BITS'(uga_pkg::sat_term(uga_pkg::PROD_BITS'(t1_reg)));
            s23_reg <= uga_pkg::SUM2_BITS'(uga_pkg::sat_term(uga_pkg::PROD_BITS'(t2_reg)))
                     + uga_pkg::SUM2_BITS'(uga_pkg::sat_term(uga_pkg::PROD_BITS'(t3_reg)));
            sum_dst_reg <= mul_dst_reg;
            sum_ok_reg  <= mul_ok_reg;
        end
    end

    // Final sum, range check and zeroing of invalid results.
    logic [uga_pkg::SUM4_BITS-1:0] total;
    logic                          fin_ok;
    uga_pkg::out_t                 fin;

    always_comb begin
        total  = uga_pkg::SUM4_BITS'(s01_reg) + uga_pkg::SUM4_BITS'(s23_reg);
        fin_ok = sum_ok_reg && (total < (uga_pkg::SUM4_BITS'(1) << uga_pkg::ADDR_BITS));
        fin.src      = fin_ok ? total[uga_pkg::ADDR_BITS-1:0] : '0;
        fin.dst      = fin_ok ? sum_dst_reg : '0;
        fin.in_range = fin_ok;
    end

    // Two-entry output buffer; entry zero drives the result ports.
    uga_pkg::out_t slot_reg [0:1];
    uga_pkg::out_t slot0_next;
    uga_pkg::out_t slot1_next;
    logic          push;
    logic          pop;

    assign push = adv && v_reg[LAST];
    assign pop  = (count_reg != BUF_EMPTY) && m_ready;

    always_comb begin
        slot0_next = slot_reg[0];
        slot1_next = slot_reg[1];
        if (pop) begin
            slot0_next = (count_reg == BUF_FULL) ? slot_reg[1] : fin;
        end else if (count_reg == BUF_EMPTY) begin
            slot0_next = fin;
        end
        if (!pop && (count_reg == BUF_ONE)) begin
            slot1_next = fin;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        slot_reg[0] <= slot0_next;
        slot_reg[1] <= slot1_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= BUF_EMPTY;
        end else begin
            count_reg <= count_next;
        end
    end

    assign m_valid     = (count_reg != BUF_EMPTY);
    assign m_src_index = slot_reg[0].src;
    assign m_dst_index = slot_reg[0].dst;
    assign m_in_range  = slot_reg[0].in_range;

    // Checks on the pipeline and the output buffer.
    `UGA_ASSERT(a_buf_count_bound, aclk, aresetn, (count_reg != 2'd3),
        "output buffer count out of range")
    `UGA_ASSERT(a_invalid_is_zero, aclk, aresetn,
        ((m_valid && !m_in_range) |-> (m_src_index == '0 && m_dst_index == '0)),
        "invalid result carries nonzero index")
    `UGA_ASSERT(a_accept_enters, aclk, aresetn, ((s_valid && s_ready) |=> v_reg[0]),
        "accepted beat missing from first stage")
    `UGA_ASSERT(a_stall_holds_last, aclk, aresetn, ((v_reg[LAST] && !adv) |=> v_reg[LAST]),
        "stalled result lost from last stage")

endmodule

`default_nettype wire

// ----- hw/rtl/uga_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none

module uga_div_pipe (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [uga_pkg::DIV_BITS-1:0] dividend,
    input  logic [uga_pkg::DIV_BITS-1:0] divisor,
    output logic [uga_pkg::DIV_BITS-1:0] quotient,
    output logic [uga_pkg::DIV_BITS-1:0] remainder
);

    localparam int N = uga_pkg::DIV_BITS;

    logic [N-1:0] rem_reg [0:N-1];
    logic [N-1:0] quo_reg [0:N-1];
    logic [N-1:0] dvd_reg [0:N-1];
    logic [N-1:0] dsr_reg [0:N-1];
    logic [N-1:0] rem_next [0:N-1];
    logic [N-1:0] quo_next [0:N-1];
    logic [N-1:0] dvd_next [0:N-1];
    logic [N-1:0] dsr_next [0:N-1];

    // Each stage shifts in the next dividend bit and subtracts the divisor
    // when the partial remainder allows it.
    always_comb begin
        logic [N-1:0] rem_p;
        logic [N-1:0] quo_p;
        logic [N-1:0] dvd_p;
        logic [N-1:0] dsr_p;
        logic [N:0]   trial;
        logic [N:0]   diff;
        logic         ge;
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                rem_p = '0;
                quo_p = '0;
                dvd_p = dividend;
                dsr_p = divisor;
            end else begin
                rem_p = rem_reg[k-1];
                quo_p = quo_reg[k-1];
                dvd_p = dvd_reg[k-1];
                dsr_p = dsr_reg[k-1];
            end
            trial = {rem_p, dvd_p[N-1]};
            diff  = trial - {1'b0, dsr_p};
            ge    = (trial >= {1'b0, dsr_p});
            rem_next[k] = ge ? diff[N-1:0] : trial[N-1:0];
            quo_next[k] = {quo_p[N-2:0], ge};
            dvd_next[k] = {dvd_p[N-2:0], 1'b0};
            dsr_next[k] = dsr_p;
        end
    end

    // All stages move together with the pipeline advance.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < N; k++) begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                dvd_reg[k] <= dvd_next[k];
                dsr_reg[k] <= dsr_next[k];
            end
        end
    end

    assign quotient  = quo_reg[N-1];
    assign remainder = rem_reg[N-1];

endmodule

`default_nettype wire

// ----- tb/gather_address_check.sv -----
`timescale 1ns / 1ps
// Checker for the unpad gather address generator: predicts each result beat and compares it.
module gather_address_check (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [uga_pkg::BATCH_BITS-1:0]     s_batch_index,
    input  logic [uga_pkg::ELEM_BITS-1:0]      s_elem_index,
    input  logic [uga_pkg::DIM_BITS-1:0]       s_true_size_a,
    input  logic [uga_pkg::DIM_BITS-1:0]       s_true_size_b,
    input  logic [uga_pkg::DIM_BITS-1:0]       s_true_size_c,
    input  logic [uga_pkg::ADDR_BITS-1:0]      s_batch_base,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [uga_pkg::ADDR_BITS-1:0]      m_src_index,
    input  logic [uga_pkg::ADDR_BITS-1:0]      m_dst_index,
    input  logic                               m_in_range,
    input  logic                               cfg_we,
    input  logic [uga_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [uga_pkg::DIM_BITS-1:0]       cfg_data,
    output int                                 fail_count,
    output int                                 pending_count
);
    import uga_pkg::*;

    // Indices saturate at 2^ADDR_BITS; anything above ADDR_TOP does not fit.
    localparam longint unsigned ADDR_SPAN = 64'd1 << ADDR_BITS;
    localparam longint unsigned ADDR_TOP  = ADDR_SPAN - 64'd1;

    // Local copy of the configuration registers.
    logic [MODE_BITS-1:0] cur_mode;
    logic [DIM_BITS-1:0]  pad_one;
    logic [DIM_BITS-1:0]  pad_two;
    logic [DIM_BITS-1:0]  pad_three;

    out_t expected_addrs[$];
    out_t want;
    int   mismatches = 0;

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    function automatic longint unsigned clamp_mul(input longint unsigned x,
                                                  input longint unsigned y);
        if (x == 0 || y == 0) return 0;
        if (x > ADDR_SPAN / y) return ADDR_SPAN;
        return (x * y > ADDR_SPAN) ? ADDR_SPAN : x * y;
    endfunction

    function automatic longint unsigned clamp_add(input longint unsigned x,
                                                  input longint unsigned y);
        return (x + y > ADDR_SPAN) ? ADDR_SPAN : x + y;
    endfunction

    // Source and destination index of one packed element under the current setting.
    function automatic out_t calc_gather_address(input logic [BATCH_BITS-1:0] n_in,
                                                 input logic [ELEM_BITS-1:0]  e_in,
                                                 input logic [DIM_BITS-1:0]   a_in,
                                                 input logic [DIM_BITS-1:0]   b_in,
                                                 input logic [DIM_BITS-1:0]   c_in,
                                                 input logic [ADDR_BITS-1:0]  base_in);
        longint unsigned n, e, a, b, c, base, p1, p2, p3;
        longint unsigned src, cnt, bc, plane, h, r, dst;
        bit   ok;
        out_t res;
        n     = n_in;
        e     = e_in;
        a     = a_in;
        b     = b_in;
        c     = c_in;
        base  = base_in;
        p1    = pad_one;
        p2    = pad_two;
        p3    = pad_three;
        src   = 0;
        ok    = 1'b0;
        case (cur_mode)
            MODE_2D: begin
                cnt = a * b;
                if (b != 0 && e < cnt) begin
                    src = clamp_mul(n, clamp_mul(p1, p2));
                    src = clamp_add(src, clamp_mul(e / b, p2));
                    src = clamp_add(src, e % b);
                    ok  = 1'b1;
                end
            end
            MODE_3D: begin
                bc  = b * c;
                cnt = a * bc;
                if (bc != 0 && e < cnt) begin
                    plane = clamp_mul(p2, p3);
                    src   = clamp_mul(n, clamp_mul(p1, plane));
                    src   = clamp_add(src, clamp_mul(e / bc, plane));
                    src   = clamp_add(src, clamp_mul((e % bc) / c, p3));
                    src   = clamp_add(src, e % c);
                    ok    = 1'b1;
                end
            end
            MODE_T0213: begin
                // Columns split into (head, head_size); head size is b / P1.
                cnt = a * b;
                if (b != 0 && p1 != 0 && e < cnt) begin
                    h = b / p1;
                    if (h != 0) begin
                        r     = e % b;
                        plane = clamp_mul(p2, p3);
                        src   = clamp_mul(n, clamp_mul(p1, plane));
                        src   = clamp_add(src, clamp_mul(r / h, plane));
                        src   = clamp_add(src, clamp_mul(e / b, p3));
                        src   = clamp_add(src, r % h);
                        ok    = 1'b1;
                    end
                end
            end
            default: ok = 1'b0;
        endcase
        dst = base + e;
        if (ok && (src > ADDR_TOP || dst > ADDR_TOP)) ok = 1'b0;
        res.src      = ok ? ADDR_BITS'(src) : '0;
        res.dst      = ok ? ADDR_BITS'(dst) : '0;
        res.in_range = ok;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned seen,
                                   input longint unsigned wanted);
        mismatches++;
        $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h",
                 $time, what, seen, wanted);
    endtask

    // Track configuration, queue a prediction per input beat, check each result beat.
    always @(posedge aclk) begin
        if (!aresetn) begin
            cur_mode  = MODE_RESET;
            pad_one   = DIM_RESET;
            pad_two   = DIM_RESET;
            pad_three = DIM_RESET;
            expected_addrs.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MODE:             cur_mode  = cfg_data[MODE_BITS-1:0];
                    CFG_PADDED_DIM_ONE:   pad_one   = cfg_data;
                    CFG_PADDED_DIM_TWO:   pad_two   = cfg_data;
                    CFG_PADDED_DIM_THREE: pad_three = cfg_data;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_addrs.push_back(calc_gather_address(s_batch_index, s_elem_index,
                    s_true_size_a, s_true_size_b, s_true_size_c, s_batch_base));
            end
            if (m_valid && m_ready) begin
                if (expected_addrs.size() == 0) begin
                    report_mismatch("unexpected result beat", 1, 0);
                end else begin
                    want = expected_addrs.pop_front();
                    if (m_src_index !== want.src)
                        report_mismatch("src_index", m_src_index, want.src);
                    if (m_dst_index !== want.dst)
                        report_mismatch("dst_index", m_dst_index, want.dst);
                    if (m_in_range !== want.in_range)
                        report_mismatch("in_range", m_in_range, want.in_range);
                end
            end
        end
        pending_count <= expected_addrs.size();
        fail_count    <= mismatches;
    end

endmodule

// ----- tb/unpad_gather_address_gen_top_tb.sv -----
`timescale 1ns / 1ps
// Top of the unpad gather address generator testbench: clock, reset, stimulus and verdict.
module unpad_gather_address_gen_top_tb;
    import uga_pkg::*;

    localparam logic [MODE_BITS-1:0] MODE_UNDEFINED = 2'd3;
    localparam int NUM_PHASES       = 12;
    localparam int RANDOM_PER_PHASE = 64;
    localparam int SETTLE_CYCLES    = 60;
    localparam int HOLD_OFF_CYCLES  = 300;

    typedef struct packed {
        logic [BATCH_BITS-1:0] n;
        logic [ELEM_BITS-1:0]  e;
        logic [DIM_BITS-1:0]   a;
        logic [DIM_BITS-1:0]   b;
        logic [DIM_BITS-1:0]   c;
        logic [ADDR_BITS-1:0]  base;
    } elem_req_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [BATCH_BITS-1:0]     s_batch_index;
    logic [ELEM_BITS-1:0]      s_elem_index;
    logic [DIM_BITS-1:0]       s_true_size_a;
    logic [DIM_BITS-1:0]       s_true_size_b;
    logic [DIM_BITS-1:0]       s_true_size_c;
    logic [ADDR_BITS-1:0]      s_batch_base;
    logic                      m_valid;
    logic                      m_ready;
    logic [ADDR_BITS-1:0]      m_src_index;
    logic [ADDR_BITS-1:0]      m_dst_index;
    logic                      m_in_range;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [DIM_BITS-1:0]       cfg_data;

    int fail_count;
    int pending_count;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_cycles        = 0;

    unpad_gather_address_gen_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_batch_index (s_batch_index),
        .s_elem_index  (s_elem_index),
        .s_true_size_a (s_true_size_a),
        .s_true_size_b (s_true_size_b),
        .s_true_size_c (s_true_size_c),
        .s_batch_base  (s_batch_base),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_src_index   (m_src_index),
        .m_dst_index   (m_dst_index),
        .m_in_range    (m_in_range),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    gather_address_check address_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_batch_index (s_batch_index),
        .s_elem_index  (s_elem_index),
        .s_true_size_a (s_true_size_a),
        .s_true_size_b (s_true_size_b),
        .s_true_size_c (s_true_size_c),
        .s_batch_base  (s_batch_base),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_src_index   (m_src_index),
        .m_dst_index   (m_dst_index),
        .m_in_range    (m_in_range),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // 50 MHz clock.
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard limit on the run.
    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Result side: random stalls, or a long hold-off when one is requested.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else begin
                m_ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    function automatic elem_req_t make_req(input int n, input int e, input int a,
                                           input int b, input int c, input int base);
        elem_req_t it;
        it.n    = BATCH_BITS'(n);
        it.e    = ELEM_BITS'(e);
        it.a    = DIM_BITS'(a);
        it.b    = DIM_BITS'(b);
        it.c    = DIM_BITS'(c);
        it.base = ADDR_BITS'(base);
        return it;
    endfunction

    // Mostly well-formed elements with random content; the rest is noise.
    function automatic elem_req_t make_random_req(input logic [MODE_BITS-1:0] m,
                                                  input int p1);
        elem_req_t       it;
        int              sel, a, b, c, h, h_top;
        longint unsigned span;
        it.n    = BATCH_BITS'($urandom);
        it.e    = ELEM_BITS'($urandom);
        it.a    = DIM_BITS'($urandom);
        it.b    = DIM_BITS'($urandom);
        it.c    = DIM_BITS'($urandom);
        it.base = ADDR_BITS'($urandom);
        sel     = $urandom_range(99);
        if (sel < 15) return it;
        a = ($urandom_range(3) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 40);
        b = ($urandom_range(3) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 40);
        c = ($urandom_range(3) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 40);
        // In the transpose mode the column count is mostly a multiple of P1.
        if (m == MODE_T0213 && p1 > 0) begin
            h_top = 4095 / p1;
            h     = $urandom_range(1, (h_top > 16) ? 16 : h_top);
            b     = p1 * h;
            if ($urandom_range(3) == 0 && b + p1 - 1 <= 4095)
                b += $urandom_range(0, p1 - 1);
        end
        it.a = DIM_BITS'(a);
        it.b = DIM_BITS'(b);
        it.c = DIM_BITS'(c);
        // Element index left random here, so mostly past the element count.
        if (sel < 30) return it;
        if (m == MODE_3D)
            span = longint'(a) * longint'(b) * longint'(c);
        else
            span = longint'(a) * longint'(b);
        if ($urandom_range(7) == 0)
            it.e = ELEM_BITS'(span - 1);
        else if (span > 64'hFF_FFFF)
            it.e = ELEM_BITS'($urandom);
        else
            it.e = ELEM_BITS'(longint'($urandom) % span);
        if ($urandom_range(3) != 0) it.n = BATCH_BITS'($urandom_range(0, 15));
        if ($urandom_range(9) == 0)
            it.base = ADDR_BITS'(32'h7FFF_FFFF - $urandom_range(0, 255));
        else
            it.base = ADDR_BITS'($urandom_range(0, 32'h7EFF_FFFF));
        return it;
    endfunction

    // Present one beat after a random idle gap and hold it until accepted.
    task automatic offer(input elem_req_t it);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_batch_index <= it.n;
        s_elem_index  <= it.e;
        s_true_size_a <= it.a;
        s_true_size_b <= it.b;
        s_true_size_c <= it.c;
        s_batch_base  <= it.base;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stop offering and wait until every predicted result has come out.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [DIM_BITS-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic phase_config(input int ph, output logic [MODE_BITS-1:0] m,
                                output int p1, output int p2, output int p3);
        case (ph)
            0:       begin m = MODE_RESET;     p1 = DIM_RESET; p2 = DIM_RESET; p3 = DIM_RESET; end
            1:       begin m = MODE_2D;        p1 = 7;    p2 = 13;   p3 = 5;    end
            2:       begin m = MODE_2D;        p1 = 4095; p2 = 4095; p3 = 4095; end
            3:       begin m = MODE_3D;        p1 = 3;    p2 = 5;    p3 = 7;    end
            4:       begin m = MODE_3D;        p1 = 4095; p2 = 4095; p3 = 4095; end
            5:       begin m = MODE_T0213;     p1 = 4;    p2 = 9;    p3 = 6;    end
            6:       begin m = MODE_T0213;     p1 = 1;    p2 = 1;    p3 = 1;    end
            7:       begin m = MODE_T0213;     p1 = 0;    p2 = 3;    p3 = 3;    end
            8:       begin m = MODE_2D;        p1 = 0;    p2 = 0;    p3 = 0;    end
            9:       begin m = MODE_UNDEFINED; p1 = 5;    p2 = 5;    p3 = 5;    end
            10:      begin m = MODE_T0213;     p1 = 16;   p2 = 4095; p3 = 4095; end
            default: begin m = MODE_3D;        p1 = 1;    p2 = 0;    p3 = 4095; end
        endcase
    endtask

    // Stimulus: one phase per register setting, directed beats first, then random ones.
    initial begin
        int                   ph;
        logic [MODE_BITS-1:0] m;
        int                   p1, p2, p3;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_batch_index = '0;
        s_elem_index  = '0;
        s_true_size_a = '0;
        s_true_size_b = '0;
        s_true_size_c = '0;
        s_batch_base  = '0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_MODE;
        cfg_data      = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            phase_config(ph, m, p1, p2, p3);
            // The first phase runs on the reset values.
            if (ph != 0) begin
                wait_idle();
                write_reg(CFG_MODE, (DIM_BITS'($urandom) << MODE_BITS) | DIM_BITS'(m));
                write_reg(CFG_PADDED_DIM_ONE, DIM_BITS'(p1));
                write_reg(CFG_PADDED_DIM_TWO, DIM_BITS'(p2));
                write_reg(CFG_PADDED_DIM_THREE, DIM_BITS'(p3));
                @(negedge aclk);
                cfg_we <= 1'b0;
            end

            case (ph % 4)
                0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1:       begin sender_idle_pct = 88; receiver_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  receiver_stall_pct = 88; end
                default: begin sender_idle_pct = 27; receiver_stall_pct = 27; end
            endcase
            // Long receiver hold-off while beats keep coming, so the input backs up.
            if (ph == 4) hold_cycles = HOLD_OFF_CYCLES;

            case (ph)
                0: begin
                    offer(make_req(0, 0, 1, 1, 1, 0));
                    // Largest element index of the largest entry, but the destination overflows.
                    offer(make_req(1023, 24'hFF_FFFF, 4095, 4095, 4095, 32'h7FFF_FFFF));
                    offer(make_req(2, 23, 2, 3, 4, 100));
                    offer(make_req(2, 24, 2, 3, 4, 100));
                    offer(make_req(5, 0, 4, 6, 0, 7));
                    offer(make_req(0, 0, 1, 1, 1, 32'h7FFF_FFFF));
                end
                1: begin
                    offer(make_req(3, 0, 5, 0, 9, 0));
                    offer(make_req(3, 34, 5, 7, 0, 1000));
                    offer(make_req(3, 35, 5, 7, 0, 1000));
                    offer(make_req(1023, 11, 4, 6, 4095, 12));
                    offer(make_req(0, 0, 0, 4095, 0, 0));
                end
                2: begin
                    // Batch stride overflows the source index; the second just fits.
                    offer(make_req(1023, 0, 1, 1, 1, 0));
                    offer(make_req(128, 0, 1, 1, 1, 0));
                end
                5: begin
                    offer(make_req(1, 17, 3, 8, 0, 5));
                    offer(make_req(1, 2, 3, 3, 0, 5));
                    offer(make_req(1, 29, 3, 10, 0, 5));
                    offer(make_req(1, 24, 3, 8, 0, 5));
                end
                7: offer(make_req(0, 1, 2, 8, 0, 0));
                9: offer(make_req(0, 0, 1, 1, 1, 0));
                default: ;
            endcase

            repeat (RANDOM_PER_PHASE) offer(make_random_req(m, p1));
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
